// ===== hw/rtl/fosp_pkg.sv =====
package fosp_pkg;

    localparam int CAM_W   = 32;
    localparam int OBJ_W   = 24;
    localparam int FRAC_W  = 8;
    localparam int DIFF_W  = CAM_W + 1;
    localparam int MAG_W   = 32;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int LEN_W   = ROOT_W - FRAC_W;
    localparam int CFG24_W = 24;
    localparam int CFG32_W = 32;
    localparam int PR_W    = MAG_W + CFG24_W;
    localparam int RN_W    = CFG24_W + CFG32_W;
    localparam int SCD_W   = RN_W - 16;
    localparam int QUO_W   = 32;
    localparam int POS_W   = 32;
    localparam int PSUM_W  = POS_W + 2;
    localparam int SCALE_W = 32;
    localparam int VIEW_W  = 24;

    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = QUO_W;

    localparam int IN_W   = 3 * CAM_W + 3 * OBJ_W;
    localparam int OUT_W  = 3 * POS_W + SCALE_W + VIEW_W;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_NEAR_LIMIT      = 2'd0,
        REG_SPHERE_RADIUS   = 2'd1,
        REG_SCALE_NUMERATOR = 2'd2,
        REG_SCALE_GAIN      = 2'd3
    } reg_idx_t;

    localparam logic [CFG24_W-1:0] NEAR_LIMIT_RST = 24'd1;
    localparam logic [CFG24_W-1:0] RADIUS_RST     = 24'd1;
    localparam logic [CFG32_W-1:0] SCALE_ONE      = 32'h0001_0000;
    localparam logic [SCALE_W-1:0] SCALE_SAT      = 32'hFFFF_FFFF;
    localparam logic [POS_W-1:0]   POS_MAX        = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0]   POS_MIN        = 32'h8000_0000;
    localparam logic [VIEW_W-1:0]  VIEW_SAT       = 24'hFF_FFFF;

    typedef logic [2:0][CAM_W-1:0] cam3_t;
    typedef logic [2:0][OBJ_W-1:0] obj3_t;
    typedef logic [2:0][PR_W-1:0]  pr3_t;

    typedef struct packed {
        cam3_t              cam;
        obj3_t              obj;
        logic [2:0]         neg;
        pr3_t               pr;
        logic [SCD_W-1:0]   dsc;
    } sqrt_side_t;

    typedef struct packed {
        cam3_t              cam;
        obj3_t              obj;
        logic [2:0]         neg;
        logic               is_near;
        logic [LEN_W-1:0]   len;
        logic               lq_zero;
        logic               len_zero;
        logic               scale_sat;
    } div_side_t;

endpackage

// ===== hw/rtl/fosp_sqrt.sv =====
module fosp_sqrt
    import fosp_pkg::*;
#(
    parameter int RW = ROOT_W
)
(
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] radicand,
    output logic [RW-1:0]   root
);

    localparam int REM_W = RW + 2;

    logic [REM_W-1:0] rem_reg  [RW];
    logic [RW-1:0]    root_reg [RW];
    logic [2*RW-1:0]  rad_reg  [RW];

    genvar i;
    generate
        for (i = 0; i < RW; i++)
        begin : g_stage
            logic [REM_W-1:0] rem_in;
            logic [RW-1:0]    root_in;
            logic [2*RW-1:0]  rad_in;
            logic [REM_W+1:0] cur;
            logic [REM_W+1:0] trial;
            logic             fits;

            if (i == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = radicand;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[i-1];
                assign root_in = root_reg[i-1];
                assign rad_in  = rad_reg[i-1];
            end

            // one root bit per stage, two radicand bits brought down
            assign cur   = {rem_in, rad_in[2*RW-1 -: 2]};
            assign trial = {{(REM_W-RW){1'b0}}, root_in, 2'b01};
            assign fits  = (cur >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i]  <= fits ? REM_W'(cur - trial) : REM_W'(cur);
                    root_reg[i] <= {root_in[RW-2:0], fits};
                    rad_reg[i]  <= {rad_in[2*RW-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[RW-1];

endmodule

// ===== hw/rtl/fosp_div.sv =====
module fosp_div
    import fosp_pkg::*;
#(
    parameter int DW = SQ_W,
    parameter int VW = ROOT_W,
    parameter int QW = QUO_W
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [QW-1:0] quotient
);

    logic [VW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [VW-1:0] dvs_reg [QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_stage
            logic [VW-1:0] rem_in;
            logic [QW-1:0] low_in;
            logic [VW-1:0] dvs_in;
            logic [VW:0]   cur;
            logic          ge;

            if (i == 0)
            begin : g_first
                // high part is below the divisor whenever the quotient fits
                assign rem_in = VW'(dividend >> QW);
                assign low_in = dividend[QW-1:0];
                assign dvs_in = divisor;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[i-1];
                assign low_in = low_reg[i-1];
                assign dvs_in = dvs_reg[i-1];
            end

            assign cur = {rem_in, low_in[QW-1]};
            assign ge  = (cur >= {1'b0, dvs_in});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= ge ? VW'(cur - {1'b0, dvs_in}) : VW'(cur);
                    low_reg[i] <= {low_in[QW-2:0], ge};
                    dvs_reg[i] <= dvs_in;
                end
            end
        end
    endgenerate

    assign quotient = low_reg[QW-1];

endmodule

// ===== hw/rtl/far_object_sphere_placement.sv =====
// throughput: one beat per cycle; a 33-stage square root and 32-stage dividers
// set the depth, a stalled output holds the whole pipeline in place
// reset: valid bits and the output valid clear, registers return to
// near_limit 1, sphere_radius 1, scale_numerator and scale_gain 1.0
module far_object_sphere_placement
    import fosp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // cam_x, cam_y, cam_z, obj_x, obj_y, obj_z
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // place_x, place_y, place_z, draw_scale, view_length
    output logic [OUT_W-1:0]  m_axis_tdata,
    // is_near
    output logic              m_axis_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int PIPE_DEPTH = 4 + SQRT_STAGES + 1 + DIV_STAGES + 1;

    logic [CFG24_W-1:0] near_limit_reg;
    logic [CFG24_W-1:0] sphere_radius_reg;
    logic [CFG32_W-1:0] scale_numerator_reg;
    logic [CFG32_W-1:0] scale_gain_reg;
    reg_idx_t           reg_idx;

    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  out_valid_reg;

    cam3_t                   cam_in;
    obj3_t                   obj_in;
    logic [2:0][DIFF_W-1:0]  a_d_next;
    logic [2:0][DIFF_W-1:0]  a_d_reg;
    cam3_t                   a_cam_reg;
    obj3_t                   a_obj_reg;

    logic [2:0][MAG_W-1:0]   b_mag_next;
    logic [2:0][MAG_W-1:0]   b_mag_reg;
    logic [2:0]              b_neg_reg;
    cam3_t                   b_cam_reg;
    obj3_t                   b_obj_reg;

    logic [2:0][SQ_W-1:0]    c_sq_next;
    logic [2:0][SQ_W-1:0]    c_sq_reg;
    pr3_t                    c_pr_next;
    pr3_t                    c_pr_reg;
    logic [RN_W-1:0]         c_rn_reg;
    logic [2:0]              c_neg_reg;
    cam3_t                   c_cam_reg;
    obj3_t                   c_obj_reg;

    logic [SUM_W-1:0]        d_sum_reg;
    sqrt_side_t              d_side_reg;

    sqrt_side_t              sq_side_reg [SQRT_STAGES];
    logic [ROOT_W-1:0]       lq;
    sqrt_side_t              sq_out;
    logic [LEN_W-1:0]        len;

    logic [2:0][SQ_W-1:0]    e_num_reg;
    logic [ROOT_W-1:0]       e_lq_reg;
    logic [SCD_W-1:0]        e_dsc_reg;
    logic [LEN_W-1:0]        e_len_reg;
    div_side_t               e_side_reg;

    div_side_t               dv_side_reg [DIV_STAGES];
    logic [2:0][QUO_W-1:0]   quo;
    logic [QUO_W-1:0]        t_quo;
    div_side_t               dv_out;

    logic [2:0][PSUM_W-1:0]  f_pos_next;
    logic [2:0][PSUM_W-1:0]  f_pos_reg;
    logic [SQ_W-1:0]         f_prod_reg;
    div_side_t               f_side_reg;

    logic [2:0][POS_W-1:0]   place;
    logic [SCALE_W-1:0]      scale;
    logic [VIEW_W-1:0]       view;
    logic [OUT_W-1:0]        out_data_reg;
    logic                    out_near_reg;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_limit_reg      <= NEAR_LIMIT_RST;
            sphere_radius_reg   <= RADIUS_RST;
            scale_numerator_reg <= SCALE_ONE;
            scale_gain_reg      <= SCALE_ONE;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_idx)
                REG_NEAR_LIMIT:      near_limit_reg      <= pwdata[CFG24_W-1:0];
                REG_SPHERE_RADIUS:   sphere_radius_reg   <= pwdata[CFG24_W-1:0];
                REG_SCALE_NUMERATOR: scale_numerator_reg <= pwdata[CFG32_W-1:0];
                REG_SCALE_GAIN:      scale_gain_reg      <= pwdata[CFG32_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_NEAR_LIMIT:      prdata = DATA_W'(near_limit_reg);
            REG_SPHERE_RADIUS:   prdata = DATA_W'(sphere_radius_reg);
            REG_SCALE_NUMERATOR: prdata = scale_numerator_reg;
            REG_SCALE_GAIN:      prdata = scale_gain_reg;
            default:             prdata = '0;
        endcase
    end

    // pipeline moves whenever the output register is free or being drained
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
            out_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    // stage a: view vector in q.8
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cam_in[k]   = s_axis_tdata[k*CAM_W +: CAM_W];
            obj_in[k]   = s_axis_tdata[3*CAM_W + k*OBJ_W +: OBJ_W];
            a_d_next[k] = {obj_in[k][OBJ_W-1], obj_in[k], {FRAC_W{1'b0}}}
                          - {cam_in[k][CAM_W-1], cam_in[k]};
        end
    end

    // stage b: magnitude and sign
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            b_mag_next[k] = a_d_reg[k][DIFF_W-1] ? MAG_W'(~a_d_reg[k] + 1'b1)
                                                 : MAG_W'(a_d_reg[k]);
        end
    end

    // stage c: squares and radius products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c_sq_next[k] = SQ_W'(b_mag_reg[k]) * SQ_W'(b_mag_reg[k]);
            c_pr_next[k] = PR_W'(b_mag_reg[k]) * PR_W'(sphere_radius_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_d_reg   <= a_d_next;
            a_cam_reg <= cam_in;
            a_obj_reg <= obj_in;

            b_mag_reg <= b_mag_next;
            for (int k = 0; k < 3; k++)
            begin
                b_neg_reg[k] <= a_d_reg[k][DIFF_W-1];
            end
            b_cam_reg <= a_cam_reg;
            b_obj_reg <= a_obj_reg;

            c_sq_reg  <= c_sq_next;
            c_pr_reg  <= c_pr_next;
            c_rn_reg  <= RN_W'(sphere_radius_reg) * RN_W'(scale_numerator_reg);
            c_neg_reg <= b_neg_reg;
            c_cam_reg <= b_cam_reg;
            c_obj_reg <= b_obj_reg;

            // stage d: sum of squares, scale dividend without its 2^16
            d_sum_reg      <= SUM_W'(c_sq_reg[0]) + SUM_W'(c_sq_reg[1])
                              + SUM_W'(c_sq_reg[2]);
            d_side_reg.cam <= c_cam_reg;
            d_side_reg.obj <= c_obj_reg;
            d_side_reg.neg <= c_neg_reg;
            d_side_reg.pr  <= c_pr_reg;
            d_side_reg.dsc <= c_rn_reg[RN_W-1 -: SCD_W];
        end
    end

    fosp_sqrt #(
        .RW (ROOT_W)
    ) u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (d_sum_reg),
        .root     (lq)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= d_side_reg;
            for (int k = 1; k < SQRT_STAGES; k++)
            begin
                sq_side_reg[k] <= sq_side_reg[k-1];
            end
        end
    end

    assign sq_out = sq_side_reg[SQRT_STAGES-1];
    assign len    = lq[ROOT_W-1:FRAC_W];

    // stage e: integer length, near test, divider operands
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e_num_reg[k] <= {sq_out.pr[k], {FRAC_W{1'b0}}};
            end
            e_lq_reg  <= lq;
            e_dsc_reg <= sq_out.dsc;
            e_len_reg <= len;

            e_side_reg.cam       <= sq_out.cam;
            e_side_reg.obj       <= sq_out.obj;
            e_side_reg.neg       <= sq_out.neg;
            e_side_reg.is_near   <= (len < LEN_W'(near_limit_reg));
            e_side_reg.len       <= len;
            e_side_reg.lq_zero   <= (lq == '0);
            e_side_reg.len_zero  <= (len == '0);
            // quotient would not fit in 32 bits
            e_side_reg.scale_sat <= (LEN_W'(sq_out.dsc[SCD_W-1:QUO_W]) >= len);
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_axis
            fosp_div #(
                .DW (SQ_W),
                .VW (ROOT_W),
                .QW (QUO_W)
            ) u_div (
                .clk      (clk),
                .en       (en),
                .dividend (e_num_reg[g]),
                .divisor  (e_lq_reg),
                .quotient (quo[g])
            );
        end
    endgenerate

    fosp_div #(
        .DW (SCD_W),
        .VW (LEN_W),
        .QW (QUO_W)
    ) u_scale_div (
        .clk      (clk),
        .en       (en),
        .dividend (e_dsc_reg),
        .divisor  (e_len_reg),
        .quotient (t_quo)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= e_side_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                dv_side_reg[k] <= dv_side_reg[k-1];
            end
        end
    end

    assign dv_out = dv_side_reg[DIV_STAGES-1];

    // stage f: far positions and scale product
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (dv_out.lq_zero)
            begin
                f_pos_next[k] = {{2{dv_out.cam[k][CAM_W-1]}}, dv_out.cam[k]};
            end
            else if (dv_out.neg[k])
            begin
                f_pos_next[k] = {{2{dv_out.cam[k][CAM_W-1]}}, dv_out.cam[k]}
                                - {2'b00, quo[k]};
            end
            else
            begin
                f_pos_next[k] = {{2{dv_out.cam[k][CAM_W-1]}}, dv_out.cam[k]}
                                + {2'b00, quo[k]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_pos_reg  <= f_pos_next;
            f_prod_reg <= SQ_W'(t_quo) * SQ_W'(scale_gain_reg);
            f_side_reg <= dv_out;
        end
    end

    // output stage: saturate and choose near or far
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (f_side_reg.is_near)
            begin
                place[k] = {f_side_reg.obj[k], {FRAC_W{1'b0}}};
            end
            else if (f_pos_reg[k][PSUM_W-1:POS_W-1] == 3'b000
                     || f_pos_reg[k][PSUM_W-1:POS_W-1] == 3'b111)
            begin
                place[k] = f_pos_reg[k][POS_W-1:0];
            end
            else if (f_pos_reg[k][PSUM_W-1])
            begin
                place[k] = POS_MIN;
            end
            else
            begin
                place[k] = POS_MAX;
            end
        end

        if (f_side_reg.is_near)
        begin
            scale = SCALE_ONE;
        end
        else if (f_side_reg.len_zero)
        begin
            scale = SCALE_SAT;
        end
        else if (f_side_reg.scale_sat)
        begin
            scale = (scale_gain_reg == '0) ? '0 : SCALE_SAT;
        end
        else if (f_prod_reg[SQ_W-1:SCALE_W] != '0)
        begin
            scale = SCALE_SAT;
        end
        else
        begin
            scale = f_prod_reg[SCALE_W-1:0];
        end

        view = f_side_reg.len[LEN_W-1:VIEW_W] != '0 ? VIEW_SAT
                                                   : f_side_reg.len[VIEW_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {view, scale, place[2], place[1], place[0]};
            out_near_reg <= f_side_reg.is_near;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_near_reg;

endmodule
